// ===== design/prad_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the paged region address decoder.
// No dependencies; every design file imports this package.
package prad_pkg;

  localparam int PAGE_COUNT   = 4096;
  localparam int REGION_SLOTS = 32;
  localparam int PAGE_SHIFT   = 12;
  localparam int ADDR_W       = 32;
  localparam int PG_W         = $clog2(PAGE_COUNT);
  localparam int ID_W         = 5;
  localparam int ENTRY_W      = $clog2(REGION_SLOTS + 1);
  localparam int TOTAL_W      = $clog2(REGION_SLOTS + 1);
  localparam int MAP_COUNT    = 3;

  // Commands
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Map selectors
  localparam logic [1:0] MAP_READ  = 2'd0;
  localparam logic [1:0] MAP_WRITE = 2'd1;
  localparam logic [1:0] MAP_FETCH = 2'd2;
  localparam logic [1:0] MAP_NONE  = 2'd3;  // names no map

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Page entry: 0 is empty, otherwise region id + 1
  typedef logic [ENTRY_W-1:0] page_entry_t;
  typedef logic [MAP_COUNT-1:0][ENTRY_W-1:0] page_row_t;

  typedef struct packed {
    logic [MAP_COUNT-1:0] lane_we;
    logic [PG_W-1:0]      addr;
    page_entry_t          data;
  } page_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic              kind;
  } region_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    region_t         data;
  } region_wr_t;

endpackage

// ===== design/prad_page_mem.sv =====
`timescale 1ns / 1ps
// Page map memory: one row per page, one lane per map (read, write, fetch).
// Depends on prad_pkg for widths and the write beat struct.
module prad_page_mem
  import prad_pkg::*;
(
  input  logic            clk,
  input  page_wr_t        wr,
  input  logic [PG_W-1:0] rd_addr,
  output page_row_t       rd_data
);

  page_row_t mem [PAGE_COUNT];
  page_row_t rd_data_r;

  // Write only the enabled lanes; read data registered.
  always_ff @(posedge clk) begin
    for (int l = 0; l < MAP_COUNT; l++) begin
      if (wr.lane_we[l]) begin
        mem[wr.addr][l] <= wr.data;
      end
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/prad_region_mem.sv =====
`timescale 1ns / 1ps
// Region store: start, inclusive end and kind of each inserted region.
// Depends on prad_pkg for the region types.
module prad_region_mem
  import prad_pkg::*;
(
  input  logic            clk,
  input  region_wr_t      wr,
  input  logic [ID_W-1:0] rd_addr,
  output region_t         rd_data
);

  region_t mem [REGION_SLOTS];
  region_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/paged_region_address_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the paged region address decoder: control sequencer and result register.
// Depends on prad_pkg, prad_page_mem and prad_region_mem.
//
//   channel | direction | handshake          | beat fields
//   --------+-----------+--------------------+-----------------------------------------------
//   in_     | input     | in_valid/in_stall   | cmd, map_select, address, end_address,
//           |           |                    | region_kind
//   out_    | output    | out_valid/out_stall | status, region_id, kind_found, offset
//
// Order: the page map row is read at the accept edge; a lookup then goes through the
// region store read, the compare and the output load, or straight to the load when the
// page entry already misses. An insert stamps its pages, if any, before the load; the
// page walk writes one page map row per cycle through the single write port. The next
// beat is taken at the earliest in the cycle after the load.
// Reset: after rst_n releases, a clearing pass writes all 4096 page rows to empty, one
// row a cycle, with in_stall high throughout. The region count resets to zero.
// Stalls: one item is in work at a time; a new beat is taken while a finished result
// still waits in the output register, and the next result waits until it drains.
module paged_region_address_decoder_top
  import prad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [1:0]        in_map_select,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_end_address,
  input  logic              in_region_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ID_W-1:0]   out_region_id,
  output logic              out_kind_found,
  output logic [ADDR_W-1:0] out_offset
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_LK_PAGE,
    S_LK_REGION,
    S_FINISH
  } state_t;

  state_t             state_r;
  logic [TOTAL_W-1:0] total_r;
  logic [PG_W-1:0]    page_r;
  logic [PG_W-1:0]    last_r;
  logic [1:0]         sel_r;
  logic [ADDR_W-1:0]  addr_r;
  page_entry_t        entry_r;

  // Pending result, moved to the output register in S_FINISH
  logic [1:0]         res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic               res_kind_r;
  logic [ADDR_W-1:0]  res_offset_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ID_W-1:0]    out_region_id_r;
  logic               out_kind_found_r;
  logic [ADDR_W-1:0]  out_offset_r;

  // Memory ports
  page_wr_t           page_wr;
  page_row_t          page_rd;
  region_wr_t         region_wr;
  logic [ID_W-1:0]    region_rd_addr;
  region_t            region_rd;

  // Decode of the accepted beat and of the page read
  logic               accept;
  logic               store_full;
  logic [ADDR_W-1:0]  first_page;
  logic [ADDR_W-1:0]  last_page_full;
  logic [ADDR_W-1:0]  last_page;
  logic               walk_needed;
  page_entry_t        page_entry;
  page_entry_t        entry_m1;
  logic               page_out_of_range;
  logic               page_miss;
  logic               region_hit;
  logic               out_load;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign store_full = (total_r == TOTAL_W'(REGION_SLOTS));

  // Load the output register from S_FINISH once it is free or drains this cycle.
  assign out_load   = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  // Page range of an insert: clip the end at the last page, never wrap.
  assign first_page     = in_address >> PAGE_SHIFT;
  assign last_page_full = in_end_address >> PAGE_SHIFT;
  assign last_page      = (last_page_full > ADDR_W'(PAGE_COUNT - 1)) ?
                          ADDR_W'(PAGE_COUNT - 1) : last_page_full;
  assign walk_needed    = (in_map_select != MAP_NONE) && (first_page <= last_page);

  // Pick the lane of the selected map; the unused selector reads as empty.
  always_comb begin
    case (sel_r)
      MAP_READ:  page_entry = page_rd[0];
      MAP_WRITE: page_entry = page_rd[1];
      MAP_FETCH: page_entry = page_rd[2];
      default:   page_entry = '0;
    endcase
  end

  assign page_out_of_range = (addr_r >> PAGE_SHIFT) >= ADDR_W'(PAGE_COUNT);
  assign page_miss         = page_out_of_range || (page_entry == '0) ||
                             (page_entry > ENTRY_W'(REGION_SLOTS));
  assign entry_m1          = page_entry - ENTRY_W'(1);
  assign region_rd_addr    = entry_m1[ID_W-1:0];
  assign region_hit        = (addr_r >= region_rd.start_addr) &&
                             (addr_r <= region_rd.end_addr);

  // Page map write: the clearing pass empties all lanes, the walk stamps one lane.
  always_comb begin
    page_wr = '0;
    case (state_r)
      S_CLEAR: begin
        page_wr.lane_we = '1;
        page_wr.addr    = page_r;
        page_wr.data    = '0;
      end
      S_WALK: begin
        page_wr.lane_we = MAP_COUNT'(1) << sel_r;
        page_wr.addr    = page_r;
        page_wr.data    = entry_r;
      end
      default: page_wr = '0;
    endcase
  end

  // Region store write on an accepted insert into a store with room.
  always_comb begin
    region_wr.en              = accept && (in_cmd == CMD_INSERT) && !store_full;
    region_wr.addr            = total_r[ID_W-1:0];
    region_wr.data.start_addr = in_address;
    region_wr.data.end_addr   = in_end_address;
    region_wr.data.kind       = in_region_kind;
  end

  prad_page_mem u_page_mem (
    .clk     (clk),
    .wr      (page_wr),
    .rd_addr (in_address[PAGE_SHIFT +: PG_W]),
    .rd_data (page_rd)
  );

  prad_region_mem u_region_mem (
    .clk     (clk),
    .wr      (region_wr),
    .rd_addr (region_rd_addr),
    .rd_data (region_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      page_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the output beat on a load, drop it once taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          if (page_r == PG_W'(PAGE_COUNT - 1)) begin
            state_r <= S_IDLE;
          end else begin
            page_r <= page_r + PG_W'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            sel_r  <= in_map_select;
            addr_r <= in_address;
            if (in_cmd == CMD_LOOKUP) begin
              state_r <= S_LK_PAGE;
            end else if (store_full) begin
              res_status_r <= ST_FULL;
              res_id_r     <= '0;
              res_kind_r   <= 1'b0;
              res_offset_r <= '0;
              state_r      <= S_FINISH;
            end else begin
              total_r      <= total_r + TOTAL_W'(1);
              entry_r      <= ENTRY_W'(total_r) + ENTRY_W'(1);
              res_status_r <= ST_OK;
              res_id_r     <= total_r[ID_W-1:0];
              res_kind_r   <= in_region_kind;
              res_offset_r <= '0;
              page_r       <= first_page[PG_W-1:0];
              last_r       <= last_page[PG_W-1:0];
              state_r      <= walk_needed ? S_WALK : S_FINISH;
            end
          end
        end

        S_WALK: begin
          // Stamp one page per cycle until the clipped last page.
          if (page_r == last_r) begin
            state_r <= S_FINISH;
          end else begin
            page_r <= page_r + PG_W'(1);
          end
        end

        S_LK_PAGE: begin
          if (page_miss) begin
            res_status_r <= ST_MISS;
            res_id_r     <= '0;
            res_kind_r   <= 1'b0;
            res_offset_r <= '0;
            state_r      <= S_FINISH;
          end else begin
            res_id_r <= region_rd_addr;
            state_r  <= S_LK_REGION;
          end
        end

        S_LK_REGION: begin
          // Check the address against the bounds of the region that owns the page.
          if (region_hit) begin
            res_status_r <= ST_OK;
            res_kind_r   <= region_rd.kind;
            res_offset_r <= addr_r - region_rd.start_addr;
          end else begin
            res_status_r <= ST_MISS;
            res_id_r     <= '0;
            res_kind_r   <= 1'b0;
            res_offset_r <= '0;
          end
          state_r <= S_FINISH;
        end

        S_FINISH: begin
          // Hold the result until the output register is free.
          if (out_load) begin
            out_status_r     <= res_status_r;
            out_region_id_r  <= res_id_r;
            out_kind_found_r <= res_kind_r;
            out_offset_r     <= res_offset_r;
            state_r          <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_region_id  = out_region_id_r;
  assign out_kind_found = out_kind_found_r;
  assign out_offset     = out_offset_r;

endmodule

// ===== tb/prad_decode_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the paged region address decoder: predicts every accepted beat and
// compares it with the result channel. Depends on prad_pkg only.
module prad_decode_checker
  import prad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_cmd,
  input  logic [1:0]        in_map_select,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_end_address,
  input  logic              in_region_kind,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic [ID_W-1:0]   out_region_id,
  input  logic              out_kind_found,
  input  logic [ADDR_W-1:0] out_offset,
  output int                owed_count,
  output int                fail_count,
  output int                hits_seen,
  output int                misses_seen,
  output int                full_seen
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   region_id;
    logic              kind;
    logic [ADDR_W-1:0] offset;
  } decode_t;

  // Page entry 0 is empty, otherwise region id + 1
  logic [ENTRY_W-1:0] page_tab [MAP_COUNT][PAGE_COUNT];
  logic [ADDR_W-1:0]  region_lo [REGION_SLOTS];
  logic [ADDR_W-1:0]  region_hi [REGION_SLOTS];
  logic               region_kind [REGION_SLOTS];
  int unsigned        region_count;
  decode_t            owed_decodes [$];
  int                 results_seen;

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    if (fail_count < PRINT_CAP)
      $display("mismatch at %0t ns, result %0d: %s got 0x%0h expected 0x%0h",
               $time, results_seen, what, got, want);
    fail_count++;
  endtask

  function automatic void predict_decode(logic cmd, logic [1:0] sel,
                                         logic [ADDR_W-1:0] addr,
                                         logic [ADDR_W-1:0] last_addr, logic kind);
    decode_t            res;
    int unsigned        pg;
    int unsigned        pg_top;
    int unsigned        id;
    logic [ENTRY_W-1:0] entry;
    res = '0;
    if (cmd == CMD_INSERT) begin
      if (region_count >= REGION_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        id = region_count;
        region_lo[id]   = addr;
        region_hi[id]   = last_addr;
        region_kind[id] = kind;
        region_count++;
        if (sel < MAP_COUNT) begin
          // clip the walk at the last page; pages past the map are never stamped
          pg_top = last_addr >> PAGE_SHIFT;
          if (pg_top > PAGE_COUNT - 1) pg_top = PAGE_COUNT - 1;
          for (pg = addr >> PAGE_SHIFT; pg <= pg_top; pg++)
            page_tab[sel][pg] = ENTRY_W'(id + 1);
        end
        res.status    = ST_OK;
        res.region_id = ID_W'(id);
        res.kind      = kind;
      end
    end else begin
      res.status = ST_MISS;
      pg = addr >> PAGE_SHIFT;
      if (sel < MAP_COUNT && pg < PAGE_COUNT) begin
        entry = page_tab[sel][pg];
        if (entry != 0 && entry <= REGION_SLOTS) begin
          id = entry - 1;
          if (addr >= region_lo[id] && addr <= region_hi[id]) begin
            res.status    = ST_OK;
            res.region_id = ID_W'(id);
            res.kind      = region_kind[id];
            res.offset    = addr - region_lo[id];
          end
        end
      end
    end
    owed_decodes = {owed_decodes, res};
  endfunction

  task automatic check_result();
    decode_t want;
    results_seen++;
    if (owed_decodes.size() == 0) begin
      report_mismatch("result with nothing owed, status", ADDR_W'(out_status), '0);
      return;
    end
    want = owed_decodes.pop_front();
    if (out_status !== want.status)
      report_mismatch("status", ADDR_W'(out_status), ADDR_W'(want.status));
    if (out_region_id !== want.region_id)
      report_mismatch("region_id", ADDR_W'(out_region_id), ADDR_W'(want.region_id));
    if (out_kind_found !== want.kind)
      report_mismatch("kind_found", ADDR_W'(out_kind_found), ADDR_W'(want.kind));
    if (out_offset !== want.offset) report_mismatch("offset", out_offset, want.offset);
    case (want.status)
      ST_FULL: full_seen++;
      ST_MISS: misses_seen++;
      default: hits_seen++;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MAP_COUNT; m++)
        for (int p = 0; p < PAGE_COUNT; p++)
          page_tab[m][p] = '0;
      region_count = 0;
      owed_decodes.delete();
    end else begin
      // retire first: a beat taken at this edge cannot have its result here yet
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        predict_decode(in_cmd, in_map_select, in_address, in_end_address, in_region_kind);
    end
    owed_count = owed_decodes.size();
  end

endmodule

// ===== tb/paged_region_address_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the paged region address decoder.
// Depends on prad_pkg, paged_region_address_decoder_top and prad_decode_checker.
module paged_region_address_decoder_top_test
  import prad_pkg::*;
();

  localparam int     RANDOM_ITEMS = 1180;
  localparam int     CALM_TAIL    = 150;   // no idling on either side for the last beats
  localparam int     HOLD_AT      = 400;   // long receiver hold-off starts here
  localparam int     HOLD_CYCLES  = 300;
  localparam int     HOLD_BEATS   = 40;    // beats offered back to back across the hold
  localparam int     PAUSE_AT     = 750;   // sender drains everything here
  localparam int     TAIL_CYCLES  = 20;
  // Watchdog limit in ns for the slowest legal run: the clear, 32 full-map walks and ~1200
  // beats with worst gaps and stalls.
  localparam longint LIMIT_NS     = 10_000_000;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_cmd         = CMD_LOOKUP;
  logic [1:0]        in_map_select  = MAP_READ;
  logic [ADDR_W-1:0] in_address     = '0;
  logic [ADDR_W-1:0] in_end_address = '0;
  logic              in_region_kind = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_region_id;
  logic              out_kind_found;
  logic [ADDR_W-1:0] out_offset;

  int owed_count, fail_count, hits_seen, misses_seen, full_seen;

  // Shared between the sender and the receiver process
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  // Regions sent so far (well-formed ones only), used to aim lookups
  logic [ADDR_W-1:0] sent_lo [$];
  logic [ADDR_W-1:0] sent_hi [$];
  logic [1:0]        sent_map [$];
  int                inserts_sent = 0;
  int                lookups_sent = 0;

  always #5 clk = ~clk;

  paged_region_address_decoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_map_select  (in_map_select),
    .in_address     (in_address),
    .in_end_address (in_end_address),
    .in_region_kind (in_region_kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_region_id  (out_region_id),
    .out_kind_found (out_kind_found),
    .out_offset     (out_offset)
  );

  prad_decode_checker u_decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_map_select  (in_map_select),
    .in_address     (in_address),
    .in_end_address (in_end_address),
    .in_region_kind (in_region_kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_region_id  (out_region_id),
    .out_kind_found (out_kind_found),
    .out_offset     (out_offset),
    .owed_count     (owed_count),
    .fail_count     (fail_count),
    .hits_seen      (hits_seen),
    .misses_seen    (misses_seen),
    .full_seen      (full_seen)
  );

  // Offer one beat and hold it until the edge that takes it. Returns at that edge, so the
  // caller may drive the next beat or drop valid without a second assignment per step.
  task automatic push_beat(logic cmd, logic [1:0] sel, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] last_addr, logic kind);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_map_select  <= sel;
    in_address     <= addr;
    in_end_address <= last_addr;
    in_region_kind <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_INSERT) begin
      inserts_sent++;
      if (addr <= last_addr) begin
        sent_lo  = {sent_lo, addr};
        sent_hi  = {sent_hi, last_addr};
        sent_map = {sent_map, sel};
      end
    end else begin
      lookups_sent++;
    end
  endtask

  // Drop valid for a random burst, unless the run is in its calm tail. Stretches of
  // 64 beats in three go by without any sender gap at all.
  task automatic sender_gap(int beat_no);
    if (!calm && (beat_no / 64) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every owed result to come back. One edge first, so the
  // checker has counted the beat taken at the current edge.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    @(posedge clk);
  endtask

  // Mostly the low 64 pages so that regions overlap and lookups land; now and then
  // anywhere in the map.
  function automatic logic [ADDR_W-1:0] window_address();
    int unsigned pg;
    pg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGE_COUNT - 1)
                                     : $urandom_range(0, 63);
    return (pg << PAGE_SHIFT) | ($urandom_range(0, 1) ? 0 : $urandom_range(0, 4095));
  endfunction

  // Receiver: random stall bursts, a long hold-off on request, none in the calm tail.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic              cmd;
    logic [1:0]        sel;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last_addr;
    logic              kind;
    int                pick;
    int                back_to_back;
    int unsigned       shape;

    back_to_back = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty maps, hits at both region edges, map isolation, start after end,
    // the unused selector, pages past the map, the walk clipped at the last page of the
    // page map, overlap, an address below start on a stamped page, a one-address
    // region and a walk over the whole fetch map.
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_0000, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_READ,  32'h0000_0000, 32'h0000_2FFF, 1'b0);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_2FFF, 32'hFFFF_FFFF, 1'b1);
    sender_gap(0);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_3000, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_WRITE, 32'h0000_1000, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_WRITE, 32'h0000_1800, 32'h0000_1100, 1'b1);
    push_beat(CMD_LOOKUP, MAP_WRITE, 32'h0000_1900, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_NONE,  32'h0000_5000, 32'h0000_6FFF, 1'b1);
    sender_gap(0);
    push_beat(CMD_LOOKUP, MAP_NONE,  32'h0000_5000, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_FETCH, 32'hFFF0_0000, 32'hFFFF_FFFF, 1'b1);
    push_beat(CMD_LOOKUP, MAP_FETCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_FETCH, 32'h00FF_F000, 32'hFFFF_FFFF, 1'b0);
    push_beat(CMD_LOOKUP, MAP_FETCH, 32'h00FF_FFFF, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_FETCH, 32'h0100_0000, 32'h0000_0000, 1'b0);
    sender_gap(0);
    push_beat(CMD_INSERT, MAP_READ,  32'h0000_2000, 32'h0000_4FFF, 1'b1);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_2ABC, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_1FFF, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_WRITE, 32'h0000_0800, 32'h0000_0FFF, 1'b0);
    push_beat(CMD_LOOKUP, MAP_WRITE, 32'h0000_0400, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_WRITE, 32'h0000_0FFF, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_READ,  32'h0000_0000, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_0000, 32'h0000_0000, 1'b0);
    push_beat(CMD_LOOKUP, MAP_READ,  32'h0000_0001, 32'h0000_0000, 1'b0);
    push_beat(CMD_INSERT, MAP_FETCH, 32'h0000_0000, 32'h00FF_FFFF, 1'b1);
    push_beat(CMD_LOOKUP, MAP_FETCH, 32'h00AB_CDEF, 32'h0000_0000, 1'b0);
    drain_all();

    // Random: inserts are frequent until the store is well past full, then rare;
    // most lookups aim inside or just outside a region sent earlier.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_TAIL);
      if (n == HOLD_AT) begin
        // hold the receiver off and keep offering beats so the block backs up
        hold_req     = 1'b1;
        back_to_back = HOLD_BEATS;
      end
      if (n == PAUSE_AT) drain_all();

      kind = 1'($urandom_range(0, 1));
      if ($urandom_range(0, (inserts_sent < 40) ? 7 : 29) == 0) begin
        cmd   = CMD_INSERT;
        sel   = ($urandom_range(0, 15) == 0) ? MAP_NONE : 2'($urandom_range(0, 2));
        shape = $urandom_range(0, 15);
        case (shape)
          0: begin
            // noise: any start, any end
            addr      = $urandom;
            last_addr = $urandom;
          end
          1: begin
            // start after end
            addr      = window_address();
            last_addr = addr - $urandom_range(1, 32'h3000);
          end
          2: begin
            // run off the end of the map
            addr      = $urandom_range(0, 4095);
            last_addr = $urandom_range(32'h00FF_F000, 32'hFFFF_FFFF);
          end
          default: begin
            addr      = window_address();
            last_addr = addr + $urandom_range(0, 16 * 4096 - 1);
          end
        endcase
      end else begin
        cmd       = CMD_LOOKUP;
        last_addr = $urandom;
        pick      = $urandom_range(0, 7);
        if (sent_lo.size() != 0 && pick < 5) begin
          shape = $urandom_range(0, sent_lo.size() - 1);
          sel   = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : sent_map[shape];
          if (pick == 4)
            // probe just past either edge
            addr = $urandom_range(0, 1) ? sent_hi[shape] + 1 : sent_lo[shape] - 1;
          else
            addr = sent_lo[shape] + $urandom_range(0, sent_hi[shape] - sent_lo[shape]);
        end else begin
          sel  = 2'($urandom_range(0, 3));
          addr = (pick < 7) ? window_address() : $urandom;
        end
      end

      push_beat(cmd, sel, addr, last_addr, kind);
      if (back_to_back > 0) back_to_back--;
      else sender_gap(n);
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d refused with the store full) and %0d lookups",
             inserts_sent, full_seen, lookups_sent);
    $display("results: %0d hits or stored inserts, %0d misses over read, write, fetch maps",
             hits_seen, misses_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/prad_pkg.sv
design/prad_page_mem.sv
design/prad_region_mem.sv
design/paged_region_address_decoder_top.sv
tb/prad_decode_checker.sv
tb/paged_region_address_decoder_top_test.sv
